>>> hw/rtl/three_stage_charge_controller_defines.svh
// Assertion macros used by the charge controller top level.
`ifndef THREE_STAGE_CHARGE_CONTROLLER_DEFINES_SVH
`define THREE_STAGE_CHARGE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tscc check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tscc check failed");

`endif

>>> hw/rtl/tscc_pkg.sv
`timescale 1ns / 1ps

package tscc_pkg;

   // Field widths.
   localparam int LEVEL_WIDTH   = 16;
   localparam int TIME_WIDTH    = 32;
   localparam int MINUTES_WIDTH = 11;
   localparam int PHASE_WIDTH   = 3;
   localparam int INDEX_WIDTH   = 3;

   // Default depth of the queue between the front and back parts.
   localparam int TSCC_QUEUE_DEPTH = 2;

   // Voltage commanded when no charging takes place (0.1 V in 10 mV units).
   localparam logic [LEVEL_WIDTH-1:0] IDLE_VOLTAGE = 16'd10;
   localparam logic [TIME_WIDTH-1:0]  MS_PER_MINUTE = 32'd60000;

   // Configuration register indexes.
   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_BULK_VOLTAGE      = 3'd0,
      REG_FLOAT_LEVEL       = 3'd1,
      REG_REBULK_LEVEL      = 3'd2,
      REG_CHARGE_LIMIT      = 3'd3,
      REG_DISCHARGE_LIMIT   = 3'd4,
      REG_ABSORPTION_MINUTES = 3'd5
   } reg_index_type;

   // Charge phases.
   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_NO_BMS = 3'd0,
      PH_WAIT   = 3'd1,
      PH_BULK   = 3'd2,
      PH_ABSORB = 3'd3,
      PH_FLOAT  = 3'd4
   } phase_type;

   // Configuration as seen by the front and back parts.
   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] bulk_voltage;
      logic [LEVEL_WIDTH-1:0] float_level;
      logic [LEVEL_WIDTH-1:0] rebulk_level;
      logic [LEVEL_WIDTH-1:0] charge_current_limit;
      logic [LEVEL_WIDTH-1:0] discharge_current_limit;
      logic [TIME_WIDTH-1:0]  absorption_ms;
   } cfg_type;

   // One classified update waiting for the back part.
   typedef struct packed {
      logic                  connected;
      logic                  reached_bulk;
      logic                  at_rebulk;
      logic [TIME_WIDTH-1:0] now_ms;
   } entry_type;

endpackage

>>> hw/rtl/tscc_cfg.sv
`timescale 1ns / 1ps

module tscc_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [tscc_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [tscc_pkg::LEVEL_WIDTH-1:0]     csr_data,
   output tscc_pkg::cfg_type                    cfg
);
   import tscc_pkg::*;

   cfg_type cfg_ff;

   // Register writes; the absorption time is kept in milliseconds so the
   // back part only needs a subtract and compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_BULK_VOLTAGE:       cfg_ff.bulk_voltage <= csr_data;
            REG_FLOAT_LEVEL:        cfg_ff.float_level <= csr_data;
            REG_REBULK_LEVEL:       cfg_ff.rebulk_level <= csr_data;
            REG_CHARGE_LIMIT:       cfg_ff.charge_current_limit <= csr_data;
            REG_DISCHARGE_LIMIT:    cfg_ff.discharge_current_limit <= csr_data;
            REG_ABSORPTION_MINUTES: begin
               cfg_ff.absorption_ms <=
                  TIME_WIDTH'(csr_data[MINUTES_WIDTH-1:0]) * MS_PER_MINUTE;
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/tscc_front.sv
`timescale 1ns / 1ps

module tscc_front (
   input  tscc_pkg::cfg_type                    cfg,
   input  logic                                 req_valid,
   input  logic                                 req_bms_connected,
   input  logic [tscc_pkg::LEVEL_WIDTH-1:0]     req_battery_level,
   input  logic [tscc_pkg::TIME_WIDTH-1:0]      req_now_ms,
   input  logic                                 queue_full,
   output logic                                 req_stall,
   output logic                                 push,
   output tscc_pkg::entry_type                  push_entry
);
   import tscc_pkg::*;

   // The front part stalls only when the queue has no room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the battery level against the configured thresholds.
   always_comb begin
      push_entry.connected    = req_bms_connected;
      push_entry.reached_bulk = (req_battery_level >= cfg.bulk_voltage);
      push_entry.at_rebulk    = (req_battery_level <= cfg.rebulk_level);
      push_entry.now_ms       = req_now_ms;
   end

endmodule

>>> hw/rtl/tscc_queue.sv
`timescale 1ns / 1ps

module tscc_queue #(
   parameter int Depth = tscc_pkg::TSCC_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tscc_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output tscc_pkg::entry_type  head_entry
);
   import tscc_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   entry_type             slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   // Pointer advance with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // Fill count.
   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CountWidth'(Depth));
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/tscc_back.sv
`timescale 1ns / 1ps

module tscc_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tscc_pkg::cfg_type                    cfg,
   input  logic                                 head_valid,
   input  tscc_pkg::entry_type                  head_entry,
   output logic                                 pop,
   output tscc_pkg::phase_type                  phase,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_command_voltage,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_charge_limit,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_discharge_limit,
   output logic [tscc_pkg::PHASE_WIDTH-1:0]     rsp_charge_phase
);
   import tscc_pkg::*;

   phase_type              phase_ff, phase_in;
   phase_type              cur_phase;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic [TIME_WIDTH-1:0]  elapsed;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0] volt_ff, volt_in;
   logic [LEVEL_WIDTH-1:0] chg_ff, chg_in;
   logic [LEVEL_WIDTH-1:0] dis_ff, dis_in;
   logic [PHASE_WIDTH-1:0] rsp_phase_ff;
   logic                   out_free;

   // The output register takes a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   // A lost BMS overrides the held phase before the transition rules.
   assign cur_phase = head_entry.connected ? phase_ff : PH_NO_BMS;
   assign elapsed   = head_entry.now_ms - start_ff;

   // Next phase and absorption start time.
   always_comb begin
      phase_in = cur_phase;
      start_in = start_ff;
      case (cur_phase)
         PH_NO_BMS: begin
            if (head_entry.connected) begin
               phase_in = PH_BULK;
            end
         end
         PH_BULK: begin
            if (head_entry.reached_bulk) begin
               phase_in = PH_ABSORB;
               start_in = head_entry.now_ms;
            end
         end
         PH_ABSORB: begin
            if (elapsed >= cfg.absorption_ms) begin
               phase_in = PH_FLOAT;
            end
         end
         PH_FLOAT: begin
            if (head_entry.at_rebulk) begin
               phase_in = PH_BULK;
            end
         end
         default: begin
         end
      endcase
   end

   // Commanded values follow the phase held before the transition.
   always_comb begin
      volt_in = IDLE_VOLTAGE;
      chg_in  = '0;
      dis_in  = '0;
      case (cur_phase)
         PH_BULK, PH_ABSORB: begin
            volt_in = cfg.bulk_voltage;
            chg_in  = cfg.charge_current_limit;
            dis_in  = cfg.discharge_current_limit;
         end
         PH_FLOAT: begin
            volt_in = cfg.float_level;
            chg_in  = cfg.charge_current_limit;
            dis_in  = cfg.discharge_current_limit;
         end
         default: begin
         end
      endcase
   end

   // Output valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NO_BMS;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            start_ff <= start_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         volt_ff      <= volt_in;
         chg_ff       <= chg_in;
         dis_ff       <= dis_in;
         rsp_phase_ff <= phase_in;
      end
   end

   assign phase               = phase_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command_voltage = volt_ff;
   assign rsp_charge_limit    = chg_ff;
   assign rsp_discharge_limit = dis_ff;
   assign rsp_charge_phase    = rsp_phase_ff;

endmodule

>>> hw/rtl/three_stage_charge_controller.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// req       req_valid/req_stall  bms_connected, battery_level, now_ms
// rsp       rsp_valid/rsp_stall  command_voltage, charge_limit, discharge_limit, charge_phase
// csr       csr_write            csr_index, csr_data (write only)
//
// One update per cycle sustained while rsp_stall stays low. The back part takes an update
// from the queue once it has been stored there and registers the result, so a request
// passes the queue slot and the result register before its result transfer.
// The queue (QueueDepth entries) absorbs result-side stalls; req_stall rises
// only when it is full. Reset is synchronous and clears the phase, queue, output valid
// and configuration registers; the result payload registers are not reset.

`include "three_stage_charge_controller_defines.svh"

module three_stage_charge_controller #(
   parameter int QueueDepth = tscc_pkg::TSCC_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_bms_connected,
   input  logic [tscc_pkg::LEVEL_WIDTH-1:0]     req_battery_level,
   input  logic [tscc_pkg::TIME_WIDTH-1:0]      req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_command_voltage,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_charge_limit,
   output logic [tscc_pkg::LEVEL_WIDTH-1:0]     rsp_discharge_limit,
   output logic [tscc_pkg::PHASE_WIDTH-1:0]     rsp_charge_phase,
   input  logic                                 csr_write,
   input  logic [tscc_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [tscc_pkg::LEVEL_WIDTH-1:0]     csr_data
);
   import tscc_pkg::*;

   cfg_type   cfg;
   entry_type push_entry;
   entry_type head_entry;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      head_valid;
   phase_type phase;

   // Configuration registers.
   tscc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Front part: accepts and classifies updates.
   tscc_front u_front (
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_bms_connected (req_bms_connected),
      .req_battery_level (req_battery_level),
      .req_now_ms        (req_now_ms),
      .queue_full        (queue_full),
      .req_stall         (req_stall),
      .push              (push),
      .push_entry        (push_entry)
   );

   // Queue between front and back.
   tscc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back part: phase machine and result register.
   tscc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .phase               (phase),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_command_voltage (rsp_command_voltage),
      .rsp_charge_limit    (rsp_charge_limit),
      .rsp_discharge_limit (rsp_discharge_limit),
      .rsp_charge_phase    (rsp_charge_phase)
   );

   // A disconnected update always reports the no-BMS phase.
   `TSCC_ASSERT_NEXT(a_lost_bms_phase, clock, reset,
      pop && !head_entry.connected,
      rsp_valid && rsp_charge_phase == PH_NO_BMS)

   // A disconnected update always carries the idle command.
   `TSCC_ASSERT_NEXT(a_lost_bms_idle, clock, reset,
      pop && !head_entry.connected,
      rsp_command_voltage == IDLE_VOLTAGE && rsp_charge_limit == '0
         && rsp_discharge_limit == '0)

   // Reaching the bulk voltage in bulk moves to absorption with live limits.
   `TSCC_ASSERT_NEXT(a_bulk_to_absorb, clock, reset,
      pop && head_entry.connected && phase == PH_BULK && head_entry.reached_bulk,
      phase == PH_ABSORB && rsp_charge_phase == PH_ABSORB
         && rsp_charge_limit == $past(cfg.charge_current_limit))

   // The queue is never written while it is full.
   `TSCC_ASSERT_SAME(a_no_overflow, clock, reset, queue_full, !push)

endmodule
